/* sv/lbca_pkg.sv */
// Shared types and constants for the LED blink-code alarm block.
// No dependencies; every other file refers to this package by scoped names.
package lbca_pkg;

	// Table geometry and field widths
	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 16;
	localparam int CODE_W    = 8;
	localparam int CNT_W     = 5;
	localparam int MAXE_W    = 5;
	localparam int TIME_W    = 4;
	localparam int TMR_W     = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd16;

	// Register index (byte address / 4)
	localparam logic REG_MAX_ENTRIES = 1'b0;

	// Request function codes
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_ADD  = 2'd1;
	localparam logic [1:0] FUNC_DEL  = 2'd2;

	// Blink timing, in ticks
	localparam logic [TIME_W-1:0] NORM_ON   = 4'd4;
	localparam logic [TIME_W-1:0] NORM_OFF  = 4'd4;
	localparam logic [TIME_W-1:0] LONG_ON   = 4'd9;
	localparam logic [TIME_W-1:0] LONG_OFF  = 4'd4;
	localparam logic [TIME_W-1:0] GAP1_OFF  = 4'd5;
	localparam logic [TIME_W-1:0] SHORT_ON  = 4'd2;
	localparam logic [TIME_W-1:0] SHORT_OFF = 4'd2;
	localparam logic [TIME_W-1:0] GAP2_OFF  = 4'd14;
	localparam logic [TIME_W-1:0] DARK_ON   = 4'd0;

	// Search token that walks down the cell chain
	typedef struct packed {
		logic             valid;
		logic             del;
		logic             found;
		logic [KEY_W-1:0] key;
	} tok_t;

	// Sequencer controls from the top-level control
	typedef struct packed {
		logic step;
		logic clamp;
	} seq_ctrl_t;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_FIRST,
		MODE_GAP_FIRST,
		MODE_SECOND,
		MODE_GAP_SECOND
	} seq_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_TICK,
		ST_REPLY
	} ctl_state_t;

endpackage

/* sv/lbca_cell.sv */
// One alarm table entry with its stage of the search token chain.
// Depends on lbca_pkg.
module lbca_cell #(
	parameter int IDX = 0,
	parameter int TW  = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lbca_pkg::tok_t            tok_in,
	output lbca_pkg::tok_t            tok_out,
	input  logic [TW-1:0]             total,
	input  logic [lbca_pkg::KEY_W-1:0] next_entry,
	input  logic                      wr_en,
	input  logic [lbca_pkg::KEY_W-1:0] wr_data,
	output logic [lbca_pkg::KEY_W-1:0] entry
);

	logic                       in_use;
	logic                       hit;
	logic                       found_here;
	lbca_pkg::tok_t             tok_q;
	logic [lbca_pkg::KEY_W-1:0] entry_q;

	// Compare only live entries
	assign in_use     = (TW'(IDX) < total);
	assign hit        = tok_in.valid && in_use && (entry_q == tok_in.key);
	assign found_here = tok_in.found || hit;

	// Token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.del   <= tok_in.del;
			tok_q.found <= found_here;
			tok_q.key   <= tok_in.key;
		end
	end

	// Entry: append write, or close the gap behind a deleted pair
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end else if (tok_in.valid && tok_in.del && found_here) begin
			entry_q <= next_entry;
		end
	end

	assign tok_out = tok_q;
	assign entry   = entry_q;

endmodule

/* sv/lbca_table.sv */
// Alarm pair table built as a row of lbca_cell stages; a search token
// enters cell 0 and passes each cell's token register in turn to leave the last cell. Depends on lbca_pkg.
module lbca_table #(
	parameter int DEPTH = lbca_pkg::DEPTH_DEF,
	parameter int TW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       del,
	input  logic [lbca_pkg::KEY_W-1:0] key,
	input  logic [TW-1:0]              total,
	input  logic                       wr_en,
	input  logic [TW-1:0]              rd_idx,
	output logic [lbca_pkg::KEY_W-1:0] rd_entry,
	output logic                       done,
	output logic                       found
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lbca_pkg::tok_t             tok [DEPTH+1];
	logic [lbca_pkg::KEY_W-1:0] ent [DEPTH];
	logic [lbca_pkg::KEY_W-1:0] key_q;

	// Token launched into the head of the chain
	always_comb begin
		tok[0].valid = start;
		tok[0].del   = del;
		tok[0].found = 1'b0;
		tok[0].key   = key;
	end

	// Pair held for the append at the end of the search
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
	end

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [lbca_pkg::KEY_W-1:0] nxt;
		if (j + 1 < DEPTH) begin : g_mid
			assign nxt = ent[j+1];
		end else begin : g_end
			assign nxt = ent[j];
		end
		lbca_cell #(
			.IDX (j),
			.TW  (TW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (tok[j]),
			.tok_out    (tok[j+1]),
			.total      (total),
			.next_entry (nxt),
			.wr_en      (wr_en && (total == TW'(j))),
			.wr_data    (key_q),
			.entry      (ent[j])
		);
	end

	assign done  = tok[DEPTH].valid;
	assign found = tok[DEPTH].found;

	// Entry shown by the sequencer
	always_comb begin
		if (rd_idx < TW'(DEPTH)) begin
			rd_entry = ent[rd_idx[AW-1:0]];
		end else begin
			rd_entry = '0;
		end
	end

endmodule

/* sv/lbca_seq.sv */
// Tick-driven blink sequencer: normal 4/4 blink, then long pulses, gap,
// short pulses and gap for each alarm pair. Depends on lbca_pkg.
module lbca_seq #(
	parameter int TW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbca_pkg::seq_ctrl_t        ctrl,
	input  logic [TW-1:0]              total,
	input  logic [lbca_pkg::KEY_W-1:0] entry,
	output logic [TW-1:0]              rd_idx,
	output logic                       led
);

	lbca_pkg::seq_mode_t mode_q, mode_d;
	logic [TW-1:0]                   idx_q, idx_d;
	logic [lbca_pkg::TMR_W-1:0]      timer_q;
	logic [lbca_pkg::TIME_W-1:0]     last_on_q, last_off_q;
	logic [lbca_pkg::CODE_W-1:0]     pc_q;
	logic                            led_q;

	logic [lbca_pkg::TIME_W-1:0] on_t, off_t;
	logic [lbca_pkg::CODE_W-1:0] cnt;
	logic                        code_mode;
	logic                        in_range;
	logic [lbca_pkg::TMR_W-1:0]  t0, t1, period;
	logic                        led_d, wrap;
	logic [lbca_pkg::CODE_W-1:0] pc1;
	logic                        code_done;
	logic [TW:0]                 idx_inc;

	assign in_range = (idx_q < total);

	// Timing and pulse count of the current phase
	always_comb begin
		on_t      = lbca_pkg::NORM_ON;
		off_t     = lbca_pkg::NORM_OFF;
		cnt       = '0;
		code_mode = 1'b0;
		unique case (mode_q)
			lbca_pkg::MODE_NORMAL: begin
				on_t  = lbca_pkg::NORM_ON;
				off_t = lbca_pkg::NORM_OFF;
			end
			lbca_pkg::MODE_FIRST: begin
				on_t      = lbca_pkg::LONG_ON;
				off_t     = lbca_pkg::LONG_OFF;
				cnt       = in_range ? entry[lbca_pkg::KEY_W-1:lbca_pkg::CODE_W] : '0;
				code_mode = 1'b1;
			end
			lbca_pkg::MODE_GAP_FIRST: begin
				on_t  = lbca_pkg::DARK_ON;
				off_t = lbca_pkg::GAP1_OFF;
			end
			lbca_pkg::MODE_SECOND: begin
				on_t      = lbca_pkg::SHORT_ON;
				off_t     = lbca_pkg::SHORT_OFF;
				cnt       = in_range ? entry[lbca_pkg::CODE_W-1:0] : '0;
				code_mode = 1'b1;
			end
			default: begin
				on_t  = lbca_pkg::DARK_ON;
				off_t = lbca_pkg::GAP2_OFF;
			end
		endcase
	end

	// One pulse timing step; a change of timing restarts the timer
	always_comb begin
		t0 = ((on_t != last_on_q) || (off_t != last_off_q)) ? '0 : timer_q;
		led_d     = (t0 < {1'b0, on_t});
		t1        = t0 + 1'b1;
		period    = {1'b0, on_t} + {1'b0, off_t};
		wrap      = (t1 >= period);
		pc1       = wrap ? pc_q + 1'b1 : pc_q;
		code_done = (pc1 >= cnt);
		idx_inc   = {1'b0, idx_q} + 1'b1;
	end

	// Next phase and table index
	always_comb begin
		mode_d = mode_q;
		idx_d  = idx_q;
		if (ctrl.step) begin
			unique case (mode_q)
				lbca_pkg::MODE_NORMAL: begin
					if (wrap && (total != '0)) begin
						idx_d  = total;
						mode_d = lbca_pkg::MODE_GAP_SECOND;
					end
				end
				lbca_pkg::MODE_FIRST: begin
					if (code_done) mode_d = lbca_pkg::MODE_GAP_FIRST;
				end
				lbca_pkg::MODE_GAP_FIRST: begin
					if (wrap) mode_d = lbca_pkg::MODE_SECOND;
				end
				lbca_pkg::MODE_SECOND: begin
					if (code_done) mode_d = lbca_pkg::MODE_GAP_SECOND;
				end
				default: begin
					if (wrap) begin
						if (total == '0) begin
							mode_d = lbca_pkg::MODE_NORMAL;
						end else begin
							idx_d  = (idx_inc >= {1'b0, total}) ? '0 : idx_inc[TW-1:0];
							mode_d = lbca_pkg::MODE_FIRST;
						end
					end
				end
			endcase
		end else if (ctrl.clamp && (idx_q >= total)) begin
			idx_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lbca_pkg::MODE_NORMAL;
			idx_q      <= '0;
			timer_q    <= '0;
			last_on_q  <= '0;
			last_off_q <= '0;
			pc_q       <= '0;
			led_q      <= 1'b0;
		end else begin
			mode_q <= mode_d;
			idx_q  <= idx_d;
			if (ctrl.step) begin
				timer_q    <= wrap ? '0 : t1;
				last_on_q  <= on_t;
				last_off_q <= off_t;
				led_q      <= led_d;
				if (code_mode) begin
					pc_q <= code_done ? '0 : pc1;
				end
			end
		end
	end

	assign rd_idx = idx_q;
	assign led    = led_q;

endmodule

/* sv/led_blink_code_alarm.sv */
// LED blink-code alarm indicator. Requests arrive one at a time: a tick
// request passes the TICK and REPLY states before its result is registered,
// an add or delete passes SEARCH and REPLY, the search token walking the row of
// table cells one cell per cycle in SEARCH. A new request is taken as soon as the
// previous one has produced its result, even if that result is still waiting
// on out_ready. max_entries sits at byte address 0 of the register port.
module led_blink_code_alarm #(
	parameter int TABLE_DEPTH = lbca_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbca_pkg::ADDR_W-1:0] paddr,
	input  logic [lbca_pkg::DATA_W-1:0] pwdata,
	output logic [lbca_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// Request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [lbca_pkg::CODE_W-1:0] first_code,
	input  logic [lbca_pkg::CODE_W-1:0] second_code,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        led_on,
	output logic [lbca_pkg::CNT_W-1:0]  entry_count
);

	localparam int TW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = (TW > lbca_pkg::MAXE_W) ? TW : lbca_pkg::MAXE_W;

	lbca_pkg::ctl_state_t state_q, state_d;
	lbca_pkg::seq_ctrl_t  seq_ctrl;

	logic [lbca_pkg::MAXE_W-1:0] max_q;
	logic [TW-1:0]               total_q;
	logic                        del_q;
	logic                        del_hit_q;
	logic                        out_valid_q;
	logic                        led_on_q;
	logic [lbca_pkg::CNT_W-1:0]  entry_count_q;

	logic                        accept;
	logic                        start;
	logic                        reg_idx;
	logic                        tbl_done, tbl_found;
	logic                        add_ok, del_ok;
	logic                        load_out;
	logic [TW-1:0]               rd_idx;
	logic [lbca_pkg::KEY_W-1:0]  rd_entry;
	logic                        led;

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lbca_pkg::MAXE_RESET;
		end else if (psel && penable && pwrite && (reg_idx == lbca_pkg::REG_MAX_ENTRIES)) begin
			max_q <= pwdata[lbca_pkg::MAXE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == lbca_pkg::REG_MAX_ENTRIES) begin
			prdata = {{(lbca_pkg::DATA_W - lbca_pkg::MAXE_W){1'b0}}, max_q};
		end
	end

	// Control decode
	always_comb begin
		in_ready       = (state_q == lbca_pkg::ST_IDLE);
		accept         = in_valid && in_ready;
		start          = accept && ((func == lbca_pkg::FUNC_ADD) || (func == lbca_pkg::FUNC_DEL));
		seq_ctrl.step  = (state_q == lbca_pkg::ST_TICK);
		seq_ctrl.clamp = (state_q == lbca_pkg::ST_REPLY) && del_hit_q;
		add_ok = (state_q == lbca_pkg::ST_SEARCH) && tbl_done && !del_q && !tbl_found
			&& (MW'(total_q) < MW'(max_q)) && (total_q < TW'(TABLE_DEPTH));
		del_ok   = (state_q == lbca_pkg::ST_SEARCH) && tbl_done && del_q && tbl_found;
		load_out = (state_q == lbca_pkg::ST_REPLY) && (!out_valid_q || out_ready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbca_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (start) begin
						state_d = lbca_pkg::ST_SEARCH;
					end else if (func == lbca_pkg::FUNC_TICK) begin
						state_d = lbca_pkg::ST_TICK;
					end else begin
						state_d = lbca_pkg::ST_REPLY;
					end
				end
			end
			lbca_pkg::ST_SEARCH: begin
				if (tbl_done) state_d = lbca_pkg::ST_REPLY;
			end
			lbca_pkg::ST_TICK: begin
				state_d = lbca_pkg::ST_REPLY;
			end
			lbca_pkg::ST_REPLY: begin
				if (load_out) state_d = lbca_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state, entry count and commit of add or delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lbca_pkg::ST_IDLE;
			total_q   <= '0;
			del_q     <= 1'b0;
			del_hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				del_q     <= (func == lbca_pkg::FUNC_DEL);
				del_hit_q <= 1'b0;
			end
			if (add_ok) begin
				total_q <= total_q + 1'b1;
			end else if (del_ok) begin
				total_q   <= total_q - 1'b1;
				del_hit_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			led_on_q      <= led;
			entry_count_q <= lbca_pkg::CNT_W'(total_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign led_on      = led_on_q;
	assign entry_count = entry_count_q;

	lbca_table #(
		.DEPTH (TABLE_DEPTH),
		.TW    (TW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.del      (func == lbca_pkg::FUNC_DEL),
		.key      ({first_code, second_code}),
		.total    (total_q),
		.wr_en    (add_ok),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.done     (tbl_done),
		.found    (tbl_found)
	);

	lbca_seq #(
		.TW (TW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (seq_ctrl),
		.total  (total_q),
		.entry  (rd_entry),
		.rd_idx (rd_idx),
		.led    (led)
	);

endmodule

/* sim/led_blink_code_alarm_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for led_blink_code_alarm: random handshakes, register writes.
// Checks LED level and pair count of every request against a built-in predictor or typed-in values.
// Needs lbca_pkg and the led_blink_code_alarm RTL, nothing else.
module led_blink_code_alarm_tb;

	localparam int DEPTH          = 16;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int GAP_MAX        = 13;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 24;
	localparam logic [lbca_pkg::ADDR_W-1:0] MAXE_ADDR = {lbca_pkg::REG_MAX_ENTRIES, 2'b00};

	typedef struct packed {
		logic                           led;
		logic [lbca_pkg::CNT_W-1:0]     count;
	} blink_result_t;

	typedef struct packed {
		logic [1:0]                     fn;
		logic [lbca_pkg::CODE_W-1:0]    hi_code;
		logic [lbca_pkg::CODE_W-1:0]    lo_code;
		logic                           typed;
		logic                           led;
		logic [lbca_pkg::CNT_W-1:0]     count;
	} plan_row_t;

	// Directed requests: expected value typed in only for the opening rows
	localparam int PLAN_LEN = 25;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{lbca_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b1, 1'b1, 5'd0},   // first tick lights the LED
		'{FUNC_NONE,           8'hFF, 8'hFF, 1'b1, 1'b1, 5'd0},   // unused func
		'{lbca_pkg::FUNC_ADD,  8'hFF, 8'hFF, 1'b1, 1'b1, 5'd1},
		'{lbca_pkg::FUNC_ADD,  8'hFF, 8'hFF, 1'b1, 1'b1, 5'd1},   // duplicate
		'{lbca_pkg::FUNC_ADD,  8'h00, 8'h00, 1'b1, 1'b1, 5'd2},
		'{lbca_pkg::FUNC_DEL,  8'h12, 8'h34, 1'b1, 1'b1, 5'd2},   // absent pair
		'{lbca_pkg::FUNC_DEL,  8'hFF, 8'hFF, 1'b1, 1'b1, 5'd1},
		'{lbca_pkg::FUNC_ADD,  8'h00, 8'h01, 1'b1, 1'b1, 5'd2},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'hA5, 8'h5A, 1'b0, 1'b0, 5'd0},
		'{lbca_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0, 1'b0, 5'd0}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [lbca_pkg::ADDR_W-1:0]    paddr;
	logic [lbca_pkg::DATA_W-1:0]    pwdata;
	logic [lbca_pkg::DATA_W-1:0]    prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_ready;
	logic [1:0]                     func;
	logic [lbca_pkg::CODE_W-1:0]    first_code;
	logic [lbca_pkg::CODE_W-1:0]    second_code;
	logic                           out_valid;
	logic                           out_ready;
	logic                           led_on;
	logic [lbca_pkg::CNT_W-1:0]     entry_count;

	led_blink_code_alarm #(
		.TABLE_DEPTH(DEPTH)
	) dut (.*);

	// Predictor state
	logic [lbca_pkg::KEY_W-1:0]     pair_mem [DEPTH];
	logic [lbca_pkg::CNT_W-1:0]     pairs_held;
	logic [lbca_pkg::CNT_W-1:0]     show_idx;
	lbca_pkg::seq_mode_t            seq_mode;
	logic [lbca_pkg::TMR_W-1:0]     seq_timer;
	logic [lbca_pkg::TIME_W-1:0]    timed_on;
	logic [lbca_pkg::TIME_W-1:0]    timed_off;
	logic [lbca_pkg::CODE_W-1:0]    pulses_shown;
	logic                           led_lvl;
	logic [lbca_pkg::MAXE_W-1:0]    pair_limit;

	blink_result_t        expected_blinks [$];
	int                   mismatches;
	int                   burst_left;
	bit                   hold_req;

	// One step of pulse timing; restarts the timer when the on/off pair changes
	function automatic logic timed_pulse(input logic [lbca_pkg::TIME_W-1:0] on_t, off_t);
		if (on_t != timed_on || off_t != timed_off) begin
			timed_on  = on_t;
			timed_off = off_t;
			seq_timer = '0;
		end
		led_lvl   = (seq_timer < lbca_pkg::TMR_W'(on_t));
		seq_timer = seq_timer + 1'b1;
		if (seq_timer >= lbca_pkg::TMR_W'(on_t) + lbca_pkg::TMR_W'(off_t)) begin
			seq_timer = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Pulse train of a code; done once count pulses have gone by
	function automatic logic code_pulse(input logic [lbca_pkg::TIME_W-1:0] on_t, off_t,
			input logic [lbca_pkg::CODE_W-1:0] count);
		if (timed_pulse(on_t, off_t))
			pulses_shown = pulses_shown + 1'b1;
		if (pulses_shown >= count) begin
			pulses_shown = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Code of the pair on show; a pair gone from the table reads as zero
	function automatic logic [lbca_pkg::CODE_W-1:0] shown_code(input logic lo_half);
		if (show_idx >= pairs_held || show_idx >= DEPTH)
			return '0;
		return lo_half ? pair_mem[show_idx[3:0]][7:0] : pair_mem[show_idx[3:0]][15:8];
	endfunction

	function automatic int pair_pos(input logic [lbca_pkg::KEY_W-1:0] key);
		for (int i = 0; i < int'(pairs_held); i++)
			if (pair_mem[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void seq_tick();
		logic done;
		case (seq_mode)
			lbca_pkg::MODE_NORMAL: begin
				done = timed_pulse(lbca_pkg::NORM_ON, lbca_pkg::NORM_OFF);
				if (done && pairs_held != 0) begin
					show_idx = pairs_held;
					seq_mode = lbca_pkg::MODE_GAP_SECOND;
				end
			end
			lbca_pkg::MODE_FIRST: begin
				if (code_pulse(lbca_pkg::LONG_ON, lbca_pkg::LONG_OFF, shown_code(1'b0)))
					seq_mode = lbca_pkg::MODE_GAP_FIRST;
			end
			lbca_pkg::MODE_GAP_FIRST: begin
				if (timed_pulse(lbca_pkg::DARK_ON, lbca_pkg::GAP1_OFF))
					seq_mode = lbca_pkg::MODE_SECOND;
			end
			lbca_pkg::MODE_SECOND: begin
				if (code_pulse(lbca_pkg::SHORT_ON, lbca_pkg::SHORT_OFF, shown_code(1'b1)))
					seq_mode = lbca_pkg::MODE_GAP_SECOND;
			end
			default: begin
				if (timed_pulse(lbca_pkg::DARK_ON, lbca_pkg::GAP2_OFF)) begin
					if (pairs_held == 0) begin
						seq_mode = lbca_pkg::MODE_NORMAL;
					end else begin
						show_idx = show_idx + 1'b1;
						if (show_idx >= pairs_held)
							show_idx = '0;
						seq_mode = lbca_pkg::MODE_FIRST;
					end
				end
			end
		endcase
	endfunction

	// Applies one accepted request to the predictor
	function automatic void apply_request(input logic [1:0] f,
			input logic [lbca_pkg::CODE_W-1:0] hi, lo);
		int pos;
		logic [lbca_pkg::KEY_W-1:0] key;
		key = {hi, lo};
		case (f)
			lbca_pkg::FUNC_TICK: seq_tick();
			lbca_pkg::FUNC_ADD: begin
				if (pair_pos(key) < 0 && pairs_held < pair_limit && pairs_held < DEPTH) begin
					pair_mem[pairs_held[3:0]] = key;
					pairs_held = pairs_held + 1'b1;
				end
			end
			lbca_pkg::FUNC_DEL: begin
				pos = pair_pos(key);
				if (pos >= 0) begin
					for (int i = pos; i + 1 < int'(pairs_held); i++)
						pair_mem[i] = pair_mem[i + 1];
					pairs_held = pairs_held - 1'b1;
					if (show_idx >= pairs_held)
						show_idx = '0;
				end
			end
			default: ;
		endcase
	endfunction

	// Mostly tiny codes so that whole blink rounds fit in the run
	function automatic logic [lbca_pkg::CODE_W-1:0] pick_code();
		if ($urandom_range(0, 19) == 0)
			return lbca_pkg::CODE_W'($urandom);
		return lbca_pkg::CODE_W'($urandom_range(0, 3));
	endfunction

	// Offers one request after a random gap, predicts once it is taken
	task automatic send_req(input logic [1:0] f, input logic [lbca_pkg::CODE_W-1:0] hi, lo,
			input logic typed, typed_led, input logic [lbca_pkg::CNT_W-1:0] typed_cnt);
		int gap;
		blink_result_t want;
		gap = (burst_left > 0) ? 0 : $urandom_range(0, GAP_MAX);
		if (burst_left > 0)
			burst_left--;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		first_code  <= hi;
		second_code <= lo;
		do @(posedge clk); while (in_ready !== 1'b1);
		apply_request(f, hi, lo);
		if (typed) begin
			want.led   = typed_led;
			want.count = typed_cnt;
		end else begin
			want.led   = led_lvl;
			want.count = pairs_held;
		end
		expected_blinks.insert(expected_blinks.size(), want);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_blinks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup then access phase on the register port
	task automatic apb_cycle(input logic wr, input logic [lbca_pkg::DATA_W-1:0] wdata,
			output logic [lbca_pkg::DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= MAXE_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_limit();
		logic [lbca_pkg::DATA_W-1:0] rd;
		apb_cycle(1'b0, '0, rd);
		if (rd[lbca_pkg::MAXE_W-1:0] !== pair_limit) begin
			$display("%0t: max_entries readback expected %0d, actual %0d",
				$time, pair_limit, rd[lbca_pkg::MAXE_W-1:0]);
			mismatches++;
		end
	endtask

	task automatic set_limit(input logic [lbca_pkg::MAXE_W-1:0] lim);
		logic [lbca_pkg::DATA_W-1:0] rd;
		apb_cycle(1'b1, lbca_pkg::DATA_W'(lim), rd);
		pair_limit = lim;
		check_limit();
	endtask

	// Random mix: mostly ticks, adds and deletes of held pairs, a little noise
	task automatic random_phase(input int n_items);
		int counted;
		int roll;
		int pos;
		logic [1:0] f;
		logic [lbca_pkg::CODE_W-1:0] hi, lo;
		counted = 0;
		while (counted < n_items) begin
			roll = $urandom_range(0, 99);
			hi = pick_code();
			lo = pick_code();
			if (roll < 62) begin
				f  = lbca_pkg::FUNC_TICK;
				hi = lbca_pkg::CODE_W'($urandom);
				lo = lbca_pkg::CODE_W'($urandom);
			end else if (roll < 80) begin
				f = lbca_pkg::FUNC_ADD;
			end else if (roll < 97) begin
				f = lbca_pkg::FUNC_DEL;
				if (pairs_held != 0 && $urandom_range(0, 4) != 0) begin
					pos = $urandom_range(0, int'(pairs_held) - 1);
					{hi, lo} = pair_mem[pos];
				end
			end else begin
				f = FUNC_NONE;
			end
			send_req(f, hi, lo, 1'b0, 1'b0, '0);
			if (f != FUNC_NONE)
				counted++;
			if ($urandom_range(0, 59) == 0)
				drain_results();
			if (burst_left == 0 && $urandom_range(0, 39) == 0)
				burst_left = 15;
		end
		drain_results();
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stall per result, one long hold-off on request
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (burst_left > 0) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, GAP_MAX);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		blink_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_blinks.size() == 0) begin
				$display("%0t: result with none expected: led_on %0d entry_count %0d",
					$time, led_on, entry_count);
				mismatches++;
			end else begin
				want = expected_blinks.pop_front();
				if (led_on !== want.led) begin
					$display("%0t: led_on expected %0d, actual %0d", $time, want.led, led_on);
					mismatches++;
				end
				if (entry_count !== want.count) begin
					$display("%0t: entry_count expected %0d, actual %0d",
						$time, want.count, entry_count);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake means the block hung
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1) ||
					(out_valid === 1'b1 && out_ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog, no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAIL led_blink_code_alarm");
		$finish;
	end

	initial begin
		int k;
		arst_n      = 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		func        <= lbca_pkg::FUNC_TICK;
		first_code  <= '0;
		second_code <= '0;
		pairs_held   = '0;
		show_idx     = '0;
		seq_mode     = lbca_pkg::MODE_NORMAL;
		seq_timer    = '0;
		timed_on     = '0;
		timed_off    = '0;
		pulses_shown = '0;
		led_lvl      = 1'b0;
		pair_limit   = lbca_pkg::MAXE_RESET;
		mismatches   = 0;
		burst_left   = 0;
		hold_req     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset value of the limit, then the directed table
		check_limit();
		for (int i = 0; i < PLAN_LEN; i++)
			send_req(PLAN[i].fn, PLAN[i].hi_code, PLAN[i].lo_code,
				PLAN[i].typed, PLAN[i].led, PLAN[i].count);
		drain_results();

		// Single-entry table
		set_limit(5'd1);
		random_phase(70);

		// Full limit with a long result hold-off while requests keep coming
		set_limit(lbca_pkg::MAXE_RESET);
		hold_req   = 1'b1;
		burst_left = 25;
		random_phase(80);

		// Fill the table, then one add past full
		k = 0;
		while (pairs_held < DEPTH) begin
			send_req(lbca_pkg::FUNC_ADD, lbca_pkg::CODE_W'(k % 4), lbca_pkg::CODE_W'(k / 4),
				1'b0, 1'b0, '0);
			k++;
		end
		send_req(lbca_pkg::FUNC_ADD, 8'hFF, 8'hFE, 1'b0, 1'b0, '0);
		drain_results();

		// Limit lowered below the held count
		set_limit(5'd2);
		random_phase(80);

		set_limit(lbca_pkg::MAXE_W'($urandom_range(3, 15)));
		random_phase(70);

		set_limit(lbca_pkg::MAXE_RESET);
		random_phase(70);

		if (mismatches == 0)
			$display("PASS led_blink_code_alarm");
		else
			$display("FAIL led_blink_code_alarm");
		$finish;
	end

endmodule

/* filelist.f */
sv/lbca_pkg.sv
sv/lbca_cell.sv
sv/lbca_table.sv
sv/lbca_seq.sv
sv/led_blink_code_alarm.sv
sim/led_blink_code_alarm_tb.sv
